@@ rtl/mandel_pkg.sv @@
// shared types and constants of the mandelbrot escape-time pixel block
package mandel_pkg;

  // fixed-point format of coordinates and of z
  localparam int FracBits = 28;
  localparam int CoordW   = 32;
  localparam int StepW    = 31;
  localparam int LimitW   = 16;
  localparam int PixW     = 12;
  localparam int MaxWidth = 4096;
  localparam int CfgIdxW  = 3;

  // step times (2*index+1), then halved
  localparam int MulW  = StepW + PixW + 1;
  localparam int HalfW = MulW - 1;
  // corner plus half product before saturation
  localparam int SumW  = HalfW + 2;
  // z values one past the escape bound, and their exact products
  localparam int ZW    = CoordW + 1;
  localparam int ProdW = 2 * ZW;

  typedef logic [ProdW:0] norm_t;

  // escape bound 4.0 in the squared scale
  localparam norm_t Four = norm_t'(4) << (2 * FracBits);

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgMinX      = 3'd0,
    CfgMaxY      = 3'd1,
    CfgStepX     = 3'd2,
    CfgStepY     = 3'd3,
    CfgIterLimit = 3'd4
  } cfg_idx_e;

  // input word: one pixel position
  typedef struct packed {
    logic [PixW-1:0] column;
    logic [PixW-1:0] row;
  } pix_in_t;

  // output word: escape result of one pixel
  typedef struct packed {
    logic [LimitW-1:0] escape_count;
    logic              inside_res;
  } pix_res_t;

  // controller states
  typedef enum logic [1:0] {
    StIdle,
    StSetup,
    StIter
  } ctrl_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic mul_c;   // multiply steps by pixel offsets
    logic set_c;   // form the point c and clear z
    logic step;    // one z = z^2 + c update
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic escaped; // current z lies outside radius 2
  } dp_sts_t;

endpackage

@@ rtl/mandel_dp.sv @@
// datapath: pixel to complex point mapping and the z = z^2 + c iteration
module mandel_dp import mandel_pkg::*; (
  input  logic                     clk_i,
  input  pix_in_t                  pixel_i,
  input  logic signed [CoordW-1:0] min_x_i,
  input  logic signed [CoordW-1:0] max_y_i,
  input  logic        [StepW-1:0]  step_x_i,
  input  logic        [StepW-1:0]  step_y_i,
  input  dp_cmd_t                  cmd_i,
  output dp_sts_t                  sts_o
);

  // clamp a wide sum to the signed coordinate range
  function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [SumW-1:0] v);
    logic signed [CoordW-1:0] r;
    if (v[SumW-1:CoordW-1] == '0 || v[SumW-1:CoordW-1] == '1) begin
      r = CoordW'(v);
    end else if (v[SumW-1]) begin
      r = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CoordW-1){1'b1}}};
    end
    return r;
  endfunction

  // reduce an index into the frame width; one subtract covers any width of 2048 or more
  function automatic logic [PixW-1:0] wrap_idx(input logic [PixW-1:0] v);
    logic [PixW-1:0] r;
    if (int'(v) >= MaxWidth) begin
      r = PixW'(int'(v) - MaxWidth);
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic        [HalfW-1:0]  half_x_q, half_x_d;
  logic        [HalfW-1:0]  half_y_q, half_y_d;
  logic signed [CoordW-1:0] cx_q, cx_d;
  logic signed [CoordW-1:0] cy_q, cy_d;
  logic signed [ProdW-1:0]  xx_q, xx_d;
  logic signed [ProdW-1:0]  yy_q, yy_d;
  logic signed [ProdW-1:0]  xy_q, xy_d;

  logic        [MulW-1:0]   mul_x, mul_y;
  logic signed [SumW-1:0]   sum_x, sum_y;
  logic signed [ProdW-1:0]  diff;
  logic signed [ProdW-1:0]  re_sh, im_sh;
  logic signed [ZW-1:0]     nx, ny;
  norm_t                    norm;

  // pixel centre offsets: step * (2*index + 1) / 2
  always_comb begin
    mul_x    = MulW'(step_x_i) * MulW'({wrap_idx(pixel_i.column), 1'b1});
    mul_y    = MulW'(step_y_i) * MulW'({wrap_idx(pixel_i.row), 1'b1});
    half_x_d = half_x_q;
    half_y_d = half_y_q;
    if (cmd_i.mul_c) begin
      half_x_d = mul_x[MulW-1:1];
      half_y_d = mul_y[MulW-1:1];
    end
  end

  // point c from the frame corner, saturated
  always_comb begin
    sum_x = SumW'(min_x_i) + $signed(SumW'(half_x_q));
    sum_y = SumW'(max_y_i) - $signed(SumW'(half_y_q));
    cx_d  = cx_q;
    cy_d  = cy_q;
    if (cmd_i.set_c) begin
      cx_d = sat_coord(sum_x);
      cy_d = sat_coord(sum_y);
    end
  end

  // one iteration: new z from the held products, then its products
  always_comb begin
    diff  = xx_q - yy_q;
    re_sh = diff >>> FracBits;
    im_sh = xy_q >>> (FracBits - 1);
    nx    = ZW'(re_sh) + ZW'(cx_q);
    ny    = ZW'(im_sh) + ZW'(cy_q);
    xx_d  = xx_q;
    yy_d  = yy_q;
    xy_d  = xy_q;
    if (cmd_i.set_c) begin
      xx_d = '0;
      yy_d = '0;
      xy_d = '0;
    end else if (cmd_i.step) begin
      xx_d = ProdW'(nx) * ProdW'(nx);
      yy_d = ProdW'(ny) * ProdW'(ny);
      xy_d = ProdW'(nx) * ProdW'(ny);
    end
  end

  // escape test on the held squares
  always_comb begin
    norm          = norm_t'($unsigned(xx_q)) + norm_t'($unsigned(yy_q));
    sts_o.escaped = (norm > Four);
  end

  always_ff @(posedge clk_i) begin
    half_x_q <= half_x_d;
    half_y_q <= half_y_d;
    cx_q     <= cx_d;
    cy_q     <= cy_d;
    xx_q     <= xx_d;
    yy_q     <= yy_d;
    xy_q     <= xy_d;
  end

endmodule

@@ rtl/mandel_ctrl.sv @@
// controller: pixel sequencing, iteration count and result register
module mandel_ctrl import mandel_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [LimitW-1:0] iter_limit_i,
  input  dp_sts_t           sts_i,
  output dp_cmd_t           cmd_o,
  output logic              busy_o,
  output logic              res_valid_o,
  output pix_res_t          res_o
);

  ctrl_state_e       state_q, state_d;
  logic [LimitW-1:0] n_q, n_d;
  logic              res_valid_q, res_valid_d;
  pix_res_t          res_q, res_d;

  // next state, commands and result capture
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    cmd_o       = '0;
    res_valid_d = 1'b0;
    res_d       = res_q;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.mul_c = 1'b1;
          state_d     = StSetup;
        end
      end
      StSetup: begin
        cmd_o.set_c = 1'b1;
        n_d         = '0;
        state_d     = StIter;
      end
      StIter: begin
        if (sts_i.escaped) begin
          // products held belong to update n, which is step n-1
          res_valid_d        = 1'b1;
          res_d.escape_count = LimitW'(n_q - 1'b1);
          res_d.inside_res   = 1'b0;
          state_d            = StIdle;
        end else if (n_q == iter_limit_i) begin
          res_valid_d        = 1'b1;
          res_d.escape_count = iter_limit_i;
          res_d.inside_res   = 1'b1;
          state_d            = StIdle;
        end else begin
          cmd_o.step = 1'b1;
          n_d        = LimitW'(n_q + 1'b1);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      n_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      res_valid_q <= res_valid_d;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy_o      = (state_q != StIdle);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ rtl/mandelbrot_escape_time_pixel.sv @@
// top level: configuration registers, controller and datapath
// steps: offsets on start, then c formed and z cleared, then z updates until escape or limit
// one pixel at a time, a new start only when idle; the multipliers make one z update per cycle
// busy drops in the cycle the result is strobed, so the next start can be taken then
// the receiver cannot stall; each result is shown for exactly one cycle
// reset: asynchronous active low; control idles and registers return to -2.0, +2.0, 1/256, 32
module mandelbrot_escape_time_pixel import mandel_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  pix_in_t            pixel_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CoordW-1:0]  cfg_data_i,
  output logic               res_valid_o,
  output pix_res_t           res_o
);

  logic signed [CoordW-1:0] min_x_q, min_x_d;
  logic signed [CoordW-1:0] max_y_q, max_y_d;
  logic        [StepW-1:0]  step_x_q, step_x_d;
  logic        [StepW-1:0]  step_y_q, step_y_d;
  logic        [LimitW-1:0] limit_q, limit_d;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  assign cfg_ready_o = 1'b1;

  // register write decode; unknown indexes are dropped
  always_comb begin
    min_x_d  = min_x_q;
    max_y_d  = max_y_q;
    step_x_d = step_x_q;
    step_y_d = step_y_q;
    limit_d  = limit_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgMinX:      min_x_d  = $signed(cfg_data_i);
        CfgMaxY:      max_y_d  = $signed(cfg_data_i);
        CfgStepX:     step_x_d = cfg_data_i[StepW-1:0];
        CfgStepY:     step_y_d = cfg_data_i[StepW-1:0];
        CfgIterLimit: limit_d  = cfg_data_i[LimitW-1:0];
        default: begin
        end
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q  <= -32'sd536870912;
      max_y_q  <= 32'sd536870912;
      step_x_q <= 31'd1048576;
      step_y_q <= 31'd1048576;
      limit_q  <= 16'd32;
    end else begin
      min_x_q  <= min_x_d;
      max_y_q  <= max_y_d;
      step_x_q <= step_x_d;
      step_y_q <= step_y_d;
      limit_q  <= limit_d;
    end
  end

  mandel_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .iter_limit_i (limit_q),
    .sts_i        (dp_sts),
    .cmd_o        (dp_cmd),
    .busy_o       (busy),
    .res_valid_o  (res_valid_o),
    .res_o        (res_o)
  );

  mandel_dp u_dp (
    .clk_i    (clk_i),
    .pixel_i  (pixel_i),
    .min_x_i  (min_x_q),
    .max_y_i  (max_y_q),
    .step_x_i (step_x_q),
    .step_y_i (step_y_q),
    .cmd_i    (dp_cmd),
    .sts_o    (dp_sts)
  );

endmodule
